// ===== design/gsmpc_pkg.sv =====
// Shared types, widths and constants of the grid-search MPC accelerator.
`default_nettype none

package gsmpc_pkg;

   // Field and datapath widths
   localparam int DATA_W  = 32;  // Q16.16 state values
   localparam int TS_W    = 17;  // time step register
   localparam int LIM_W   = 19;  // acceleration limit register
   localparam int OUT_A_W = 19;  // result acceleration
   localparam int ACC_W   = 21;  // candidate acceleration, covers up to 36 candidates
   localparam int COST_W  = 64;  // Q32.32 cost
   localparam int PROD_W  = 2 * DATA_W;

   // Parameter defaults
   localparam int HORIZON_DEF        = 10;
   localparam int NUM_CANDIDATES_DEF = 9;

   // Candidate grid: first value -2.0, step 0.5
   localparam logic signed [ACC_W-1:0] ACC_FIRST = -21'sd131072;
   localparam logic signed [ACC_W-1:0] ACC_STEP  = 21'sd32768;

   // Result acceleration range
   localparam logic signed [OUT_A_W-1:0] OUT_ACC_MAX = 19'sd262143;
   localparam logic signed [OUT_A_W-1:0] OUT_ACC_MIN = -19'sd262144;

   // Register map: index = paddr[2]
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [0:0] REG_TIME_STEP   = 1'b0;
   localparam logic [0:0] REG_ACCEL_LIMIT = 1'b1;
   localparam logic [TS_W-1:0]  TIME_STEP_RST   = 17'd6554;
   localparam logic [LIM_W-1:0] ACCEL_LIMIT_RST = 19'd131072;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_A_W-1:0] best_accel;
      logic                      found;
      logic [COST_W-1:0]         best_cost;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_RUN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FINISH
   } ctrl_state_type;

   // Multiplier operations; each tags what its product updates
   typedef enum logic [2:0] {
      OP_VX_DT,
      OP_VY_DT,
      OP_VZ_DT,
      OP_A_DT,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_Z
   } op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic   load_in;
      logic   cand_first;
      logic   cand_next;
      logic   cand_start;
      logic   mul_en;
      op_type mul_sel;
      logic   decide;
      logic   out_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic cand_ok;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== design/gsmpc_dp.sv =====
// Datapath: input latch, Euler state, shared multiplier, cost and best-candidate registers.
`default_nettype none

module gsmpc_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gsmpc_pkg::dp_cmd_type         cmd,
   output gsmpc_pkg::dp_sts_type              sts,
   input  wire gsmpc_pkg::req_type            req_data,
   input  wire logic [gsmpc_pkg::TS_W-1:0]    time_step,
   input  wire logic [gsmpc_pkg::LIM_W-1:0]   accel_limit,
   output gsmpc_pkg::rsp_type                 rsp_data
);

   localparam int DW = gsmpc_pkg::DATA_W;
   localparam int AW = gsmpc_pkg::ACC_W;
   localparam int CW = gsmpc_pkg::COST_W;
   localparam int PW = gsmpc_pkg::PROD_W;
   localparam int SW = DW + 2;  // position add before clamping

   // p + floor(prod / 2^16), clamped to 32 bits
   function automatic logic signed [DW-1:0] step_sat(input logic signed [DW-1:0] base,
                                                     input logic signed [PW-1:0] prod);
      logic signed [SW-1:0] sum;
      sum = {{2{base[DW-1]}}, base} + prod[SW+15:16];
      if (sum[SW-1:DW-1] == '0 || sum[SW-1:DW-1] == '1) begin
         step_sat = sum[DW-1:0];
      end else if (sum[SW-1]) begin
         step_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         step_sat = {1'b0, {(DW-1){1'b1}}};
      end
   endfunction

   gsmpc_pkg::req_type       in_ff, in_in;
   logic signed [DW-1:0]     px_ff, px_in, py_ff, py_in, pz_ff, pz_in, vx_ff, vx_in;
   logic [CW-1:0]            cost_ff, cost_in;
   logic [CW-1:0]            best_cost_ff, best_cost_in;
   logic signed [AW-1:0]     best_a_ff, best_a_in;
   logic                     found_ff, found_in;
   logic signed [AW-1:0]     cand_a_ff, cand_a_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   gsmpc_pkg::op_type        prod_op_ff, prod_op_in;
   logic                     prod_vld_ff, prod_vld_in;
   gsmpc_pkg::rsp_type       rsp_ff, rsp_in;

   logic signed [DW-1:0]     mul_a, mul_b, dt_s;
   logic [AW-1:0]            mag_a;
   logic [CW:0]              cost_sum;
   logic signed [gsmpc_pkg::OUT_A_W-1:0] out_a;

   assign dt_s = $signed({{(DW-gsmpc_pkg::TS_W){1'b0}}, time_step});

   // Limit test on the current candidate
   always_comb begin
      mag_a = cand_a_ff[AW-1] ? AW'(-cand_a_ff) : AW'(cand_a_ff);
      sts.cand_ok = (mag_a <= AW'(accel_limit));
   end

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         gsmpc_pkg::OP_VX_DT: begin mul_a = vx_ff;        mul_b = dt_s;  end
         gsmpc_pkg::OP_VY_DT: begin mul_a = in_ff.vel_y;  mul_b = dt_s;  end
         gsmpc_pkg::OP_VZ_DT: begin mul_a = in_ff.vel_z;  mul_b = dt_s;  end
         gsmpc_pkg::OP_A_DT:  begin mul_a = DW'(cand_a_ff); mul_b = dt_s; end
         gsmpc_pkg::OP_SQ_X:  begin mul_a = px_ff;        mul_b = px_ff; end
         gsmpc_pkg::OP_SQ_Y:  begin mul_a = py_ff;        mul_b = py_ff; end
         gsmpc_pkg::OP_SQ_Z:  begin mul_a = pz_ff;        mul_b = pz_ff; end
         default:             begin mul_a = '0;           mul_b = '0;    end
      endcase
      prod_in     = mul_a * mul_b;
      prod_op_in  = cmd.mul_sel;
      prod_vld_in = cmd.mul_en;
   end

   // Saturating cost accumulation of a registered square
   assign cost_sum = {1'b0, cost_ff} + {1'b0, prod_ff};

   // Apply the registered product, start candidates, keep the best
   always_comb begin
      in_in        = in_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      vx_in        = vx_ff;
      cost_in      = cost_ff;
      best_cost_in = best_cost_ff;
      best_a_in    = best_a_ff;
      found_in     = found_ff;
      cand_a_in    = cand_a_ff;

      if (cmd.load_in) begin
         in_in        = req_data;
         found_in     = 1'b0;
         best_a_in    = '0;
         best_cost_in = '1;
      end
      if (cmd.cand_first) begin
         cand_a_in = gsmpc_pkg::ACC_FIRST;
      end
      if (cmd.cand_next) begin
         cand_a_in = cand_a_ff + gsmpc_pkg::ACC_STEP;
      end
      if (cmd.cand_start) begin
         px_in   = in_ff.pos_x;
         py_in   = in_ff.pos_y;
         pz_in   = in_ff.pos_z;
         vx_in   = in_ff.vel_x;
         cost_in = '0;
      end
      if (prod_vld_ff) begin
         case (prod_op_ff)
            gsmpc_pkg::OP_VX_DT: px_in = step_sat(px_ff, prod_ff);
            gsmpc_pkg::OP_VY_DT: py_in = step_sat(py_ff, prod_ff);
            gsmpc_pkg::OP_VZ_DT: pz_in = step_sat(pz_ff, prod_ff);
            gsmpc_pkg::OP_A_DT:  vx_in = step_sat(vx_ff, prod_ff);
            gsmpc_pkg::OP_SQ_X,
            gsmpc_pkg::OP_SQ_Y,
            gsmpc_pkg::OP_SQ_Z:  cost_in = cost_sum[CW] ? '1 : cost_sum[CW-1:0];
            default:             cost_in = cost_ff;
         endcase
      end
      // First passing candidate always wins; later ones need a strictly lower cost
      if (cmd.decide && (!found_ff || cost_ff < best_cost_ff)) begin
         found_in     = 1'b1;
         best_cost_in = cost_ff;
         best_a_in    = cand_a_ff;
      end
   end

   // Clamp the chosen acceleration to the result width
   always_comb begin
      if (best_a_ff > AW'(gsmpc_pkg::OUT_ACC_MAX)) begin
         out_a = gsmpc_pkg::OUT_ACC_MAX;
      end else if (best_a_ff < AW'(gsmpc_pkg::OUT_ACC_MIN)) begin
         out_a = gsmpc_pkg::OUT_ACC_MIN;
      end else begin
         out_a = best_a_ff[gsmpc_pkg::OUT_A_W-1:0];
      end
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.best_accel = out_a;
         rsp_in.found      = found_ff;
         rsp_in.best_cost  = best_cost_ff;
      end
   end

   // Control bit of the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff        <= in_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      vx_ff        <= vx_in;
      cost_ff      <= cost_in;
      best_cost_ff <= best_cost_in;
      best_a_ff    <= best_a_in;
      found_ff     <= found_in;
      cand_a_ff    <= cand_a_in;
      prod_ff      <= prod_in;
      prod_op_ff   <= prod_op_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== design/gsmpc_ctrl.sv =====
// Controller: sequences candidates, horizon steps and multiplier operations.
`default_nettype none

module gsmpc_ctrl #(
   parameter int HORIZON        = gsmpc_pkg::HORIZON_DEF,
   parameter int NUM_CANDIDATES = gsmpc_pkg::NUM_CANDIDATES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output gsmpc_pkg::dp_cmd_type       cmd,
   input  wire gsmpc_pkg::dp_sts_type  sts
);

   localparam int STEP_W = $clog2(HORIZON);
   localparam int CAND_W = $clog2(NUM_CANDIDATES);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HORIZON - 1);
   localparam logic [CAND_W-1:0] CAND_LAST = CAND_W'(NUM_CANDIDATES - 1);

   gsmpc_pkg::ctrl_state_type state_ff, state_in;
   gsmpc_pkg::op_type         op_ff, op_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [CAND_W-1:0]         cand_ff, cand_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // State register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsmpc_pkg::ST_IDLE;
         op_ff        <= gsmpc_pkg::OP_SQ_X;
         step_ff      <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.mul_sel  = op_ff;
      req_ready    = 1'b0;

      // Drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         gsmpc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in    = 1'b1;
               cmd.cand_first = 1'b1;
               cand_in        = '0;
               state_in       = gsmpc_pkg::ST_CAND;
            end
         end
         gsmpc_pkg::ST_CAND: begin
            if (sts.cand_ok) begin
               cmd.cand_start = 1'b1;
               step_in        = '0;
               op_in          = gsmpc_pkg::OP_SQ_X;
               state_in       = gsmpc_pkg::ST_RUN;
            end else if (cand_ff == CAND_LAST) begin
               state_in = gsmpc_pkg::ST_FINISH;
            end else begin
               cmd.cand_next = 1'b1;
               cand_in       = cand_ff + 1'b1;
            end
         end
         gsmpc_pkg::ST_RUN: begin
            cmd.mul_en = 1'b1;
            case (op_ff)
               gsmpc_pkg::OP_VX_DT: op_in = gsmpc_pkg::OP_VY_DT;
               gsmpc_pkg::OP_VY_DT: op_in = gsmpc_pkg::OP_VZ_DT;
               gsmpc_pkg::OP_VZ_DT: op_in = gsmpc_pkg::OP_A_DT;
               gsmpc_pkg::OP_A_DT:  op_in = gsmpc_pkg::OP_SQ_X;
               gsmpc_pkg::OP_SQ_X:  op_in = gsmpc_pkg::OP_SQ_Y;
               gsmpc_pkg::OP_SQ_Y:  op_in = gsmpc_pkg::OP_SQ_Z;
               gsmpc_pkg::OP_SQ_Z: begin
                  if (step_ff == STEP_LAST) begin
                     state_in = gsmpc_pkg::ST_DRAIN;
                  end else begin
                     step_in = step_ff + 1'b1;
                     op_in   = gsmpc_pkg::OP_VX_DT;
                  end
               end
               default: op_in = gsmpc_pkg::OP_SQ_X;
            endcase
         end
         gsmpc_pkg::ST_DRAIN: begin
            // last square is added this cycle
            state_in = gsmpc_pkg::ST_DECIDE;
         end
         gsmpc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (cand_ff == CAND_LAST) begin
               state_in = gsmpc_pkg::ST_FINISH;
            end else begin
               cmd.cand_next = 1'b1;
               cand_in       = cand_ff + 1'b1;
               state_in      = gsmpc_pkg::ST_CAND;
            end
         end
         gsmpc_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = gsmpc_pkg::ST_IDLE;
            end
         end
         default: state_in = gsmpc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/grid_search_mpc_accel_core.sv =====
// Top level: register port, controller and datapath of the grid-search MPC accelerator.
// Each candidate within the limit is run over the horizon, drained and decided; one beyond
//   the limit is skipped. A new item is taken only after the current one is finished,
//   since the single shared 32x32 multiplier runs every Euler product and every square in turn.
// Reset (synchronous, active high) empties the result register, returns the sequencer
//   to idle and loads time_step = 6554 and accel_limit = 131072.
`default_nettype none

module grid_search_mpc_accel_core #(
   parameter int HORIZON        = gsmpc_pkg::HORIZON_DEF,
   parameter int NUM_CANDIDATES = gsmpc_pkg::NUM_CANDIDATES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire gsmpc_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output gsmpc_pkg::rsp_type                     rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [gsmpc_pkg::PADDR_W-1:0]     paddr,
   input  wire logic [gsmpc_pkg::PDATA_W-1:0]     pwdata,
   output logic [gsmpc_pkg::PDATA_W-1:0]          prdata,
   output logic                                   pready
);

   logic [gsmpc_pkg::TS_W-1:0]  time_step_ff, time_step_in;
   logic [gsmpc_pkg::LIM_W-1:0] accel_limit_ff, accel_limit_in;
   logic                        wr_en;
   logic [0:0]                  reg_idx;

   gsmpc_pkg::dp_cmd_type cmd;
   gsmpc_pkg::dp_sts_type sts;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2:2];
   assign wr_en   = psel & penable & pwrite & pready;

   // Write the configuration registers on the access cycle
   always_comb begin
      time_step_in   = time_step_ff;
      accel_limit_in = accel_limit_ff;
      if (wr_en) begin
         case (reg_idx)
            gsmpc_pkg::REG_TIME_STEP:   time_step_in   = pwdata[gsmpc_pkg::TS_W-1:0];
            gsmpc_pkg::REG_ACCEL_LIMIT: accel_limit_in = pwdata[gsmpc_pkg::LIM_W-1:0];
            default:                    time_step_in   = time_step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= gsmpc_pkg::TIME_STEP_RST;
         accel_limit_ff <= gsmpc_pkg::ACCEL_LIMIT_RST;
      end else begin
         time_step_ff   <= time_step_in;
         accel_limit_ff <= accel_limit_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         gsmpc_pkg::REG_TIME_STEP:
            prdata = gsmpc_pkg::PDATA_W'(time_step_ff);
         gsmpc_pkg::REG_ACCEL_LIMIT:
            prdata = gsmpc_pkg::PDATA_W'(accel_limit_ff);
         default:
            prdata = '0;
      endcase
   end

   gsmpc_ctrl #(
      .HORIZON        (HORIZON),
      .NUM_CANDIDATES (NUM_CANDIDATES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   gsmpc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .time_step   (time_step_ff),
      .accel_limit (accel_limit_ff),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/gsmpc_checker.sv =====
// Port-level checker for the grid-search MPC accelerator and its bind.
`default_nettype none

module gsmpc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire gsmpc_pkg::rsp_type            rsp_data,
   input wire logic                          pready
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No passing candidate reports zero acceleration and an infinite cost
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.best_accel == '0 && rsp_data.best_cost == '1)
      else $error("empty search reported a value");

   // Block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !(rsp_valid && $rose(rsp_valid)))
      else $error("accepted a second item or finished at once");

   // Reset empties the result register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind grid_search_mpc_accel_core gsmpc_checker u_gsmpc_checker (.*);

`default_nettype wire
